FILE: rtl/core/apt_pkg.sv
// shared constants, codes and controller/datapath types for the peer table
package apt_pkg;

    localparam int unsigned APT_ENTRIES = 32;
    localparam int unsigned ID_W        = 32;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_W       = 32;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [TIME_W-1:0] FORGET_RST  = 32'd2000;
    localparam logic [TIME_W-1:0] HOLDOFF_RST = 32'd1000;
    localparam logic [TIME_W-1:0] TIME_MAX    = 32'hFFFF_FFFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORGET  = 1'b0,
        CFG_HOLDOFF = 1'b1
    } t_cfg_idx;

    // item command codes
    typedef enum logic [0:0] {
        CMD_SIGHT  = 1'b0,
        CMD_SWITCH = 1'b1
    } t_item_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FIRST,
        ST_SIGHT_WALK,
        ST_SIGHT_TAIL,
        ST_INSERT,
        ST_SW_WALK,
        ST_DONE
    } t_apt_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic first_wr;
        logic addr_zero;
        logic addr_next;
        logic rd_en;
        logic sight_eval;
        logic insert;
        logic sw_check;
        logic sw_eval;
        logic out_load;
    } t_apt_cmd;

    // datapath to controller
    typedef struct packed {
        logic item_sw;
        logic have_active;
        logic hold_ok;
        logic can_walk;
        logic sw_found;
        logic out_busy;
    } t_apt_sts;

endpackage

FILE: rtl/core/apt_if.sv
// valid/ready channels for input words and result words

interface apt_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] sender_id;
    logic [31:0] now_ms;

    modport source (output valid, command, sender_id, now_ms, input ready);
    modport sink   (input valid, command, sender_id, now_ms, output ready);
endinterface

interface apt_out_if;
    logic        valid;
    logic        ready;
    logic        active_valid;
    logic [31:0] active_id;
    logic        blink_send;
    logic [31:0] blink_target;

    modport source (output valid, active_valid, active_id, blink_send, blink_target,
                    input ready);
    modport sink   (input valid, active_valid, active_id, blink_send, blink_target,
                    output ready);
endinterface

FILE: rtl/core/apt_ctrl.sv
// sequencer for sighting walks, switch walks and result hand-off
module apt_ctrl #(
    parameter int unsigned TABLE_ENTRIES = apt_pkg::APT_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  apt_pkg::t_apt_sts i_sts,
    output apt_pkg::t_apt_cmd o_cmd
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    apt_pkg::t_apt_state r_state, n_state;
    logic [IW-1:0]       r_cnt, n_cnt;

    // state and walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apt_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            apt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_cnt      = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = apt_pkg::ST_DECODE;
                end
            end
            apt_pkg::ST_DECODE: begin
                if (i_sts.item_sw) begin
                    o_cmd.sw_check = 1'b1;
                    if (i_sts.hold_ok && i_sts.can_walk) begin
                        o_cmd.addr_next = 1'b1;
                        n_state         = apt_pkg::ST_SW_WALK;
                    end else begin
                        n_state = apt_pkg::ST_DONE;
                    end
                end else if (!i_sts.have_active) begin
                    n_state = apt_pkg::ST_FIRST;
                end else begin
                    o_cmd.addr_zero = 1'b1;
                    n_state         = apt_pkg::ST_SIGHT_WALK;
                end
            end
            apt_pkg::ST_FIRST: begin
                o_cmd.first_wr = 1'b1;
                n_state        = apt_pkg::ST_DONE;
            end
            apt_pkg::ST_SIGHT_WALK: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.sight_eval = 1'b1;
                n_cnt            = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = apt_pkg::ST_SIGHT_TAIL;
                end
            end
            apt_pkg::ST_SIGHT_TAIL: begin
                o_cmd.sight_eval = 1'b1;
                n_state          = apt_pkg::ST_INSERT;
            end
            apt_pkg::ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = apt_pkg::ST_DONE;
            end
            apt_pkg::ST_SW_WALK: begin
                // the active entry is nonzero, so a hit comes within one lap
                o_cmd.rd_en   = 1'b1;
                o_cmd.sw_eval = 1'b1;
                if (i_sts.sw_found) begin
                    n_state = apt_pkg::ST_DONE;
                end
            end
            apt_pkg::ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = apt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = apt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/apt_dp.sv
// table memories, active entry tracking, config registers and result register
module apt_dp #(
    parameter int unsigned TABLE_ENTRIES = apt_pkg::APT_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [apt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [apt_pkg::CFG_W-1:0]      i_cfg_data,
    // input word payload
    input  logic                           i_command,
    input  logic [apt_pkg::ID_W-1:0]       i_sender_id,
    input  logic [apt_pkg::TIME_W-1:0]     i_now_ms,
    // result word
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_active_valid,
    output logic [apt_pkg::ID_W-1:0]       o_active_id,
    output logic                           o_blink_send,
    output logic [apt_pkg::ID_W-1:0]       o_blink_target,
    // controller link
    input  apt_pkg::t_apt_cmd              i_cmd,
    output apt_pkg::t_apt_sts              o_sts
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // table storage, read as zero until first written
    logic [apt_pkg::ID_W-1:0]   mem_id   [TABLE_ENTRIES];
    logic [apt_pkg::TIME_W-1:0] mem_time [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   r_vld;

    logic [apt_pkg::TIME_W-1:0] r_forget, r_holdoff;
    logic                       r_cmd;
    logic [apt_pkg::ID_W-1:0]   r_who;
    logic [apt_pkg::TIME_W-1:0] r_now, r_limit, r_last;

    logic                       r_have;
    logic [IW-1:0]              r_act_idx;
    logic [apt_pkg::ID_W-1:0]   r_act_id;

    logic [IW-1:0]              r_addr, r_rd_idx;
    logic                       r_rd_pend, r_rd_vld;
    logic [apt_pkg::ID_W-1:0]   r_rd_id;
    logic [apt_pkg::TIME_W-1:0] r_rd_time;

    logic                       r_found;
    logic [IW-1:0]              r_old_idx;
    logic [apt_pkg::TIME_W-1:0] r_old_time;
    logic                       r_blink;
    logic [apt_pkg::ID_W-1:0]   r_target;

    logic                       r_out_vld, r_out_act_vld, r_out_blink;
    logic [apt_pkg::ID_W-1:0]   r_out_act_id, r_out_target;

    logic [apt_pkg::ID_W-1:0]   rd_id, id_kept;
    logic [apt_pkg::TIME_W-1:0] rd_time, time_kept, hold_end;
    logic                       hit, stale, older, eval_now;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    logic [apt_pkg::ID_W-1:0]   wr_id;
    logic [apt_pkg::TIME_W-1:0] wr_time;
    logic [IW-1:0]              act_next;

    // entry read back, never-written entries read as zero
    assign rd_id   = r_rd_vld ? r_rd_id   : '0;
    assign rd_time = r_rd_vld ? r_rd_time : '0;

    // sighting evaluation of one entry
    assign eval_now  = i_cmd.sight_eval && r_rd_pend;
    assign hit       = (rd_id == r_who);
    assign stale     = (rd_time < r_limit) && (rd_id != r_act_id);
    assign id_kept   = stale ? '0 : rd_id;
    assign time_kept = stale ? '0 : rd_time;
    assign older     = !hit && (time_kept < r_old_time) && (id_kept != r_act_id);

    assign hold_end  = r_last + r_holdoff;
    assign act_next  = (r_act_idx == LAST_IDX) ? '0 : r_act_idx + 1'b1;

    // status to controller
    always_comb begin
        o_sts             = '0;
        o_sts.item_sw     = (r_cmd == apt_pkg::CMD_SWITCH);
        o_sts.have_active = r_have;
        o_sts.hold_ok     = !(r_now < hold_end);
        o_sts.can_walk    = r_have && (r_act_id != '0);
        o_sts.sw_found    = i_cmd.sw_eval && r_rd_pend && (rd_id != '0);
        o_sts.out_busy    = r_out_vld && !i_out_ready;
    end

    // single write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_idx;
        wr_id   = r_who;
        wr_time = r_now;
        if (i_cmd.first_wr) begin
            wr_en   = 1'b1;
            wr_addr = '0;
        end else if (i_cmd.insert) begin
            wr_en   = !r_found;
            wr_addr = r_old_idx;
        end else if (eval_now) begin
            if (hit) begin
                wr_en = 1'b1;
                wr_id = rd_id;
            end else if (stale) begin
                wr_en   = 1'b1;
                wr_id   = '0;
                wr_time = '0;
            end
        end
    end

    // table memories with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_id[wr_addr]   <= wr_id;
            mem_time[wr_addr] <= wr_time;
        end
        if (i_cmd.rd_en) begin
            r_rd_id   <= mem_id[r_addr];
            r_rd_time <= mem_time[r_addr];
        end
    end

    // written-entry flags and read pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_pend <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_addr    <= '0;
            r_rd_idx  <= '0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_rd_pend <= i_cmd.rd_en;
            if (i_cmd.addr_zero) begin
                r_addr <= '0;
            end else if (i_cmd.addr_next) begin
                r_addr <= act_next;
            end else if (i_cmd.rd_en) begin
                r_addr   <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
                r_rd_idx <= r_addr;
                r_rd_vld <= r_vld[r_addr];
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forget  <= apt_pkg::FORGET_RST;
            r_holdoff <= apt_pkg::HOLDOFF_RST;
        end else if (i_cfg_we) begin
            unique case (apt_pkg::t_cfg_idx'(i_cfg_idx))
                apt_pkg::CFG_FORGET:  r_forget  <= i_cfg_data;
                apt_pkg::CFG_HOLDOFF: r_holdoff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latched word and age limit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_who   <= i_sender_id;
            r_now   <= i_now_ms;
            r_limit <= i_now_ms - r_forget;
        end
    end

    // active entry, switch time, walk results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_act_idx  <= '0;
            r_act_id   <= '0;
            r_last     <= '0;
            r_found    <= 1'b0;
            r_old_idx  <= '0;
            r_old_time <= apt_pkg::TIME_MAX;
            r_blink    <= 1'b0;
            r_target   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_found    <= 1'b0;
                r_old_idx  <= '0;
                r_old_time <= apt_pkg::TIME_MAX;
                r_blink    <= 1'b0;
                r_target   <= '0;
            end
            if (eval_now) begin
                if (hit) begin
                    r_found <= 1'b1;
                end
                if (older) begin
                    r_old_idx  <= r_rd_idx;
                    r_old_time <= time_kept;
                end
            end
            // keep the active id in step with writes to the active entry
            if (wr_en && r_have && (wr_addr == r_act_idx)) begin
                r_act_id <= wr_id;
            end
            if (i_cmd.first_wr) begin
                r_have    <= 1'b1;
                r_act_idx <= '0;
                r_act_id  <= r_who;
            end
            if (i_cmd.sw_check && o_sts.hold_ok) begin
                r_last <= r_now;
            end
            if (o_sts.sw_found) begin
                r_act_idx <= r_rd_idx;
                r_act_id  <= rd_id;
                r_blink   <= 1'b1;
                r_target  <= rd_id;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_act_vld <= r_have;
            r_out_act_id  <= r_have ? r_act_id : '0;
            r_out_blink   <= r_blink;
            r_out_target  <= r_target;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_active_valid = r_out_act_vld;
    assign o_active_id    = r_out_act_id;
    assign o_blink_send   = r_out_blink;
    assign o_blink_target = r_out_target;

endmodule

FILE: rtl/core/aging_peer_table_with_rotation.sv
// top level of the aging peer table with active-entry rotation
// One word at a time. A sighting walks the whole table through a single
// registered read port, one entry per cycle; the first sighting after reset
// instead writes entry 0 with no walk. A switch request goes straight to the
// result when held off or when there is nothing to rotate, and otherwise
// walks from the entry after the active one to the next nonzero ID. A new
// word is taken while the previous result still waits in the output
// register. The table resets to all zeros through per-entry written flags,
// so there is no clearing pass.
// Configuration writes belong in idle time between words.
module aging_peer_table_with_rotation #(
    parameter int unsigned TABLE_ENTRIES = apt_pkg::APT_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [apt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [apt_pkg::CFG_W-1:0]     i_cfg_data,
    apt_in_if.sink                        i_in,
    apt_out_if.source                     o_out
);

    apt_pkg::t_apt_cmd cmd;
    apt_pkg::t_apt_sts sts;

    // controller
    apt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    apt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_in.command),
        .i_sender_id    (i_in.sender_id),
        .i_now_ms       (i_in.now_ms),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_active_valid (o_out.active_valid),
        .o_active_id    (o_out.active_id),
        .o_blink_send   (o_out.blink_send),
        .o_blink_target (o_out.blink_target),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule

FILE: rtl/core/apt_check.sv
// port-level checks for the peer table, bound to the top level
module apt_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_active_valid,
    input logic [31:0] i_active_id,
    input logic        i_blink_send,
    input logic [31:0] i_blink_target
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_active_id)
                                           && $stable(i_blink_target)))
        else $error("result word dropped or changed while stalled");

    // one word in flight: no back-to-back accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second word accepted while busy");

    // a blink goes to the new active entry
    a_blink_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_blink_send) |-> (i_active_valid && i_blink_target == i_active_id))
        else $error("blink target is not the active id");

    // no blink, no target
    a_no_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_blink_send) |-> (i_blink_target == 32'd0))
        else $error("blink target set without a blink");

    // nothing active reads as id zero
    a_no_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_active_valid) |-> (i_active_id == 32'd0))
        else $error("active id nonzero with no active entry");

endmodule

bind aging_peer_table_with_rotation apt_check u_apt_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_active_valid (o_out.active_valid),
    .i_active_id    (o_out.active_id),
    .i_blink_send   (o_out.blink_send),
    .i_blink_target (o_out.blink_target)
);
